@@ rtl/bdar_pkg.sv @@
// Shared types and constants for the button debounce and auto-repeat unit.
// No dependencies; every other file of the block imports this package.
package bdar_pkg;

  // Widths fixed by the item and register formats.
  localparam int unsigned RAW_W    = 4;
  localparam int unsigned LIMIT_W  = 8;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INITIAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [LIMIT_W-1:0] DEBOUNCE_LIMIT_RST = 8'd5;
  localparam logic [HOLD_W-1:0]  REPEAT_INITIAL_RST = 16'd500;
  localparam logic [HOLD_W-1:0]  REPEAT_PERIOD_RST  = 16'd100;

  // Item modes.
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  // Current configuration as seen by every lane.
  typedef struct packed {
    logic [LIMIT_W-1:0] debounce_limit;
    logic [HOLD_W-1:0]  repeat_initial;
    logic [HOLD_W-1:0]  repeat_period;
  } cfg_t;

  // Per-lane control for one processed item.
  typedef struct packed {
    logic tick;   // apply a tick with the given level
    logic check;  // report and update the last-seen flag
    logic level;  // raw pressed level for this button
  } lane_ctl_t;

endpackage

@@ rtl/button_debounce_autorepeat_unit.sv @@
// Top level of the button debounce and auto-repeat unit: input register,
// button lanes, result register. Depends on bdar_pkg, bdar_cfg_regs, bdar_lane.
//
// Usage:
// - Input channel (in_valid/in_ready): in_mode 0 is a tick carrying the raw
//   pressed levels in in_raw_pressed; in_mode 1 is a check that reports
//   debounced rising edges since the previous check.
// - Result channel (out_valid/out_ready): one result per transaction with
//   out_press_events (zero on ticks) and out_debounced, the debounced levels
//   after the item. Only buttons 0 to 3 appear on the ports; buttons beyond
//   the fourth see a released raw level.
// - Configuration channel (cfg_valid/cfg_ready, always ready): index 0 is
//   the debounce limit, 1 the initial repeat delay, 2 the repeat period.
//   Write only while the unit is idle.
// - An accepted item waits in the input register; its result then goes to
//   the result register. Throughput: one item per cycle while out_ready
//   holds, set by the single update pass into lane state and result register.
// - Stall: while a result waits, one more item is taken into the input
//   register; then in_ready drops until out_ready frees the result register.
// - Reset (rst_n low, synchronous) releases all buttons, clears all counters
//   and restores the register reset values.
module button_debounce_autorepeat_unit
  import bdar_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 4
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [RAW_W-1:0]     in_raw_pressed,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RAW_W-1:0]     out_press_events,
  output logic [RAW_W-1:0]     out_debounced,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t cfg;

  logic             in_vld_r,  in_vld_nxt;
  logic             in_mode_r;
  logic [RAW_W-1:0] in_raw_r;
  logic             out_vld_r, out_vld_nxt;
  logic [RAW_W-1:0] out_events_r;
  logic [RAW_W-1:0] out_level_r;

  logic                   advance;
  logic                   in_accept;
  logic [NUM_BUTTONS-1:0] stable_nxt;
  logic [NUM_BUTTONS-1:0] press_event;
  logic [RAW_W-1:0]       events_vec;
  logic [RAW_W-1:0]       level_vec;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  bdar_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Handshake: the held item moves on when the result register is free.
  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_mode_r <= in_mode;
      in_raw_r  <= in_raw_pressed;
    end
  end

  // One lane per button; buttons past the raw field see released.
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    lane_ctl_t ctl;
    logic      raw_level;

    if (i < RAW_W) begin : g_raw
      assign raw_level = in_raw_r[i];
    end else begin : g_released
      assign raw_level = 1'b0;
    end

    assign ctl.tick  = advance && (in_mode_r == MODE_TICK);
    assign ctl.check = advance && (in_mode_r == MODE_CHECK);
    assign ctl.level = raw_level;

    bdar_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .cfg           (cfg),
      .stable_nxt_o  (stable_nxt[i]),
      .press_event_o (press_event[i])
    );
  end

  // Only the first four buttons reach the result fields.
  for (genvar b = 0; b < RAW_W; b++) begin : g_out_bit
    if (b < NUM_BUTTONS) begin : g_used
      assign events_vec[b] = press_event[b];
      assign level_vec[b]  = stable_nxt[b];
    end else begin : g_unused
      assign events_vec[b] = 1'b0;
      assign level_vec[b]  = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_events_r <= events_vec;
      out_level_r  <= level_vec;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_press_events = out_events_r;
  assign out_debounced    = out_level_r;

endmodule

@@ rtl/bdar_cfg_regs.sv @@
// Configuration register file for the button debounce and auto-repeat unit.
// Depends on bdar_pkg for the register indexes, reset values and cfg_t.
module bdar_cfg_regs
  import bdar_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_DAT_W-1:0] wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; an unknown index leaves every register unchanged.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_DEBOUNCE_LIMIT: cfg_nxt.debounce_limit = wr_data[LIMIT_W-1:0];
        REG_REPEAT_INITIAL: cfg_nxt.repeat_initial = wr_data[HOLD_W-1:0];
        REG_REPEAT_PERIOD:  cfg_nxt.repeat_period  = wr_data[HOLD_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_limit <= DEBOUNCE_LIMIT_RST;
      cfg_r.repeat_initial <= REPEAT_INITIAL_RST;
      cfg_r.repeat_period  <= REPEAT_PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/bdar_lane.sv @@
// State and update logic of one button: debounce counter, hold counter,
// repeat phase and last-seen flag. Depends on bdar_pkg for cfg_t and lane_ctl_t.
module bdar_lane
  import bdar_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  lane_ctl_t ctl,
  input  cfg_t      cfg,
  output logic      stable_nxt_o,
  output logic      press_event_o
);

  logic               stable_r,    stable_nxt;
  logic [LIMIT_W-1:0] agree_r,     agree_nxt;
  logic               last_seen_r, last_seen_nxt;
  logic [HOLD_W-1:0]  hold_r,      hold_nxt;
  logic               repeating_r, repeating_nxt;

  logic [HOLD_W-1:0]  hold_inc;
  logic [HOLD_W-1:0]  hold_limit;

  assign hold_inc   = hold_r + HOLD_W'(1);
  assign hold_limit = repeating_r ? cfg.repeat_period : cfg.repeat_initial;

  // Press event: debounced level pressed and not yet reported.
  assign press_event_o = ctl.check && stable_r && !last_seen_r;

  // Next state for a tick or a check.
  always_comb begin
    stable_nxt    = stable_r;
    agree_nxt     = agree_r;
    last_seen_nxt = last_seen_r;
    hold_nxt      = hold_r;
    repeating_nxt = repeating_r;

    if (ctl.tick) begin
      // Up/down debounce counter; flip once the limit has been passed.
      if (ctl.level == stable_r) begin
        if (agree_r != '0) begin
          agree_nxt = agree_r - LIMIT_W'(1);
        end
      end else if (agree_r < cfg.debounce_limit) begin
        agree_nxt = agree_r + LIMIT_W'(1);
      end else begin
        stable_nxt = ctl.level;
        agree_nxt  = '0;
      end

      // Held buttons count toward the next auto-repeat press.
      if (stable_nxt) begin
        hold_nxt = hold_inc;
        if (hold_inc >= hold_limit) begin
          last_seen_nxt = 1'b0;
          hold_nxt      = '0;
          repeating_nxt = 1'b1;
        end
      end else begin
        hold_nxt      = '0;
        repeating_nxt = 1'b0;
      end
    end else if (ctl.check) begin
      last_seen_nxt = stable_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r    <= 1'b0;
      agree_r     <= '0;
      last_seen_r <= 1'b0;
      hold_r      <= '0;
      repeating_r <= 1'b0;
    end else begin
      stable_r    <= stable_nxt;
      agree_r     <= agree_nxt;
      last_seen_r <= last_seen_nxt;
      hold_r      <= hold_nxt;
      repeating_r <= repeating_nxt;
    end
  end

  assign stable_nxt_o = stable_nxt;

endmodule

@@ tb/tb_button_debounce_autorepeat_unit.sv @@
// Self-checking testbench for button_debounce_autorepeat_unit: a directed table, then phases
// of random button activity under several idling patterns, checked by an in-bench predictor
// and typed expectations. Depends on bdar_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_button_debounce_autorepeat_unit
  import bdar_pkg::*;
;

  localparam int NUM_BTN = RAW_W;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int NUM_ROWS = 34;
  // Index past the register list; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [RAW_W-1:0] press_events;
    logic [RAW_W-1:0] debounced;
  } btn_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic                 mode;
    logic [RAW_W-1:0]     raw;
    logic                 has_exp;
    logic [RAW_W-1:0]     exp_events;
    logic [RAW_W-1:0]     exp_level;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] dat;
  } row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_mode;
  logic [RAW_W-1:0]     in_raw_pressed;
  logic                 out_valid;
  logic                 out_ready;
  logic [RAW_W-1:0]     out_press_events;
  logic [RAW_W-1:0]     out_debounced;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // Expected results in order of acceptance, and a typed override for the current item.
  btn_result_t press_report_q[$];
  logic        item_has_exp;
  btn_result_t item_exp;
  int          err_count;
  int          quiet_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;

  // Predictor copy of the register file.
  logic [LIMIT_W-1:0] cur_limit;
  logic [HOLD_W-1:0]  cur_initial;
  logic [HOLD_W-1:0]  cur_period;

  // Predictor copy of the per-button state.
  logic               lvl_stable [NUM_BTN];
  logic [LIMIT_W-1:0] bounce_cnt [NUM_BTN];
  logic               seen_flag  [NUM_BTN];
  logic [HOLD_W-1:0]  held_ticks [NUM_BTN];
  logic               in_repeat  [NUM_BTN];

  row_t steps [0:NUM_ROWS-1];

  button_debounce_autorepeat_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_raw_pressed   (in_raw_pressed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_press_events (out_press_events),
    .out_debounced    (out_debounced),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Advance the predicted button state by one item and return its result.
  task automatic predict_item(input logic mode, input logic [RAW_W-1:0] raw,
                              output btn_result_t res);
    logic [HOLD_W-1:0] thr;
    res = '0;
    for (int i = 0; i < NUM_BTN; i++) begin
      if (mode == MODE_TICK) begin
        // Debounce counter: drain on agreement, climb on disagreement, flip past the limit.
        if (raw[i] == lvl_stable[i]) begin
          if (bounce_cnt[i] != 0) bounce_cnt[i] = bounce_cnt[i] - 1'b1;
        end else if (bounce_cnt[i] < cur_limit) begin
          bounce_cnt[i] = bounce_cnt[i] + 1'b1;
        end else begin
          lvl_stable[i] = raw[i];
          bounce_cnt[i] = '0;
        end
        // Held buttons count toward the initial delay, then the repeat period.
        if (lvl_stable[i]) begin
          thr = in_repeat[i] ? cur_period : cur_initial;
          held_ticks[i] = held_ticks[i] + 1'b1;
          if (held_ticks[i] >= thr) begin
            seen_flag[i] = 1'b0;
            held_ticks[i] = '0;
            in_repeat[i] = 1'b1;
          end
        end else begin
          held_ticks[i] = '0;
          in_repeat[i] = 1'b0;
        end
      end else begin
        res.press_events[i] = lvl_stable[i] && !seen_flag[i];
        seen_flag[i] = lvl_stable[i];
      end
    end
    for (int i = 0; i < NUM_BTN; i++) res.debounced[i] = lvl_stable[i];
  endtask

  // Lower the input valid and wait until every expected result has come, plus a margin.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (press_report_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] dat);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = dat;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Present one input transaction, after a random gap when the sender is idling.
  task automatic send_item(input logic mode, input logic [RAW_W-1:0] raw, input logic has_exp,
                           input logic [RAW_W-1:0] exp_events,
                           input logic [RAW_W-1:0] exp_level);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid       = 1'b1;
    in_mode        = mode;
    in_raw_pressed = raw;
    item_has_exp   = has_exp;
    item_exp       = {exp_events, exp_level};
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver: random back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    out_ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Track register writes and accepted items, and check every accepted result.
  always @(posedge clk) begin : result_mon
    btn_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE_LIMIT: cur_limit = cfg_data[LIMIT_W-1:0];
          REG_REPEAT_INITIAL: cur_initial = cfg_data;
          REG_REPEAT_PERIOD:  cur_period = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_item(in_mode, in_raw_pressed, want);
        if (item_has_exp) want = item_exp;
        press_report_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (press_report_q.size() == 0) begin
          err_count++;
          $display("%0t ns: unexpected result, got events %h debounced %h",
                   $time, out_press_events, out_debounced);
        end else begin
          want = press_report_q.pop_front();
          if (out_press_events !== want.press_events) begin
            err_count++;
            $display("%0t ns: press_events mismatch, expected %h, got %h",
                     $time, want.press_events, out_press_events);
          end
          if (out_debounced !== want.debounced) begin
            err_count++;
            $display("%0t ns: debounced mismatch, expected %h, got %h",
                     $time, want.debounced, out_debounced);
          end
        end
      end
    end
  end

  // Watchdog: too many cycles without any transaction ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [RAW_W-1:0] hold_pattern;
    logic [RAW_W-1:0] raw;
    int               pick;

    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_TICK;
    in_raw_pressed = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_DEBOUNCE_LIMIT;
    cfg_data       = '0;
    item_has_exp   = 1'b0;
    item_exp       = '0;
    err_count      = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_pattern   = '0;
    cur_limit      = DEBOUNCE_LIMIT_RST;
    cur_initial    = REPEAT_INITIAL_RST;
    cur_period     = REPEAT_PERIOD_RST;
    for (int i = 0; i < NUM_BTN; i++) begin
      lvl_stable[i] = 1'b0;
      bounce_cnt[i] = '0;
      seen_flag[i]  = 1'b0;
      held_ticks[i] = '0;
      in_repeat[i]  = 1'b0;
    end

    // Directed rows. Typed expectations only where they follow directly from reset or a
    // zero debounce limit; the rest go through the predictor.
    steps = '{
      // After reset: nothing pressed, a check reports nothing and ignores its raw field.
      '{ROW_ITEM, MODE_CHECK, 4'hF, 1'b1, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_TICK,  4'h0, 1'b1, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_TICK,  4'hF, 1'b1, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      // Default limit: the sixth disagreeing tick flips all buttons.
      '{ROW_ITEM, MODE_TICK,  4'hF, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_TICK,  4'hF, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_TICK,  4'hF, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_TICK,  4'hF, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_TICK,  4'hF, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_CHECK, 4'h0, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      // Upper data bits are dropped, leaving a zero limit; the unused index is ignored.
      '{ROW_REG,  MODE_TICK,  4'h0, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'hFF00},
      '{ROW_REG,  MODE_TICK,  4'h0, 1'b0, 4'h0, 4'h0, REG_UNUSED,         16'hFFFF},
      '{ROW_ITEM, MODE_TICK,  4'h0, 1'b1, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_TICK,  4'h5, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_CHECK, 4'h0, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      // Zero repeat thresholds: every held tick re-arms the press report.
      '{ROW_REG,  MODE_TICK,  4'h0, 1'b0, 4'h0, 4'h0, REG_REPEAT_INITIAL, 16'h0000},
      '{ROW_REG,  MODE_TICK,  4'h0, 1'b0, 4'h0, 4'h0, REG_REPEAT_PERIOD,  16'h0000},
      '{ROW_ITEM, MODE_TICK,  4'hA, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_CHECK, 4'h0, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_TICK,  4'hA, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_CHECK, 4'h0, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      // Largest settings, then the limit lowered below the running counter.
      '{ROW_REG,  MODE_TICK,  4'h0, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h00FF},
      '{ROW_REG,  MODE_TICK,  4'h0, 1'b0, 4'h0, 4'h0, REG_REPEAT_INITIAL, 16'hFFFF},
      '{ROW_REG,  MODE_TICK,  4'h0, 1'b0, 4'h0, 4'h0, REG_REPEAT_PERIOD,  16'hFFFF},
      '{ROW_ITEM, MODE_TICK,  4'h0, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_TICK,  4'h0, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_REG,  MODE_TICK,  4'h0, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0001},
      '{ROW_ITEM, MODE_TICK,  4'h0, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_TICK,  4'hF, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_TICK,  4'hF, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_TICK,  4'hF, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      // Initial delay lowered below the held count: the next held tick fires.
      '{ROW_REG,  MODE_TICK,  4'h0, 1'b0, 4'h0, 4'h0, REG_REPEAT_INITIAL, 16'h0001},
      '{ROW_ITEM, MODE_TICK,  4'hF, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_CHECK, 4'h0, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000},
      '{ROW_ITEM, MODE_TICK,  4'h0, 1'b0, 4'h0, 4'h0, REG_DEBOUNCE_LIMIT, 16'h0000}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int k = 0; k < NUM_ROWS; k++) begin
      if (steps[k].kind == ROW_REG) begin
        write_reg(steps[k].idx, steps[k].dat);
      end else begin
        send_item(steps[k].mode, steps[k].raw, steps[k].has_exp,
                  steps[k].exp_events, steps[k].exp_level);
      end
    end

    // Random phases: each picks an idling pattern and a register setting, then runs
    // mostly steady presses with some contact bounce, checks and pure noise.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (ph == 0) begin
        write_reg(REG_DEBOUNCE_LIMIT, 16'hFFFF);
        write_reg(REG_REPEAT_INITIAL, 16'hFFFF);
        write_reg(REG_REPEAT_PERIOD, 16'hFFFF);
      end else if (ph == 1) begin
        write_reg(REG_DEBOUNCE_LIMIT, 16'h0000);
        write_reg(REG_REPEAT_INITIAL, 16'h0000);
        write_reg(REG_REPEAT_PERIOD, 16'h0000);
      end else begin
        write_reg(REG_DEBOUNCE_LIMIT, CFG_DAT_W'($urandom_range(6)));
        write_reg(REG_REPEAT_INITIAL, CFG_DAT_W'($urandom_range(40)));
        write_reg(REG_REPEAT_PERIOD, CFG_DAT_W'($urandom_range(15)));
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold off once until the unit has drained completely.
        if (ph == 2 && n == ITEMS_PER_PHASE / 2) wait_idle();
        pick = $urandom_range(99);
        if (pick < 18) begin
          send_item(MODE_CHECK, RAW_W'($urandom_range(15)), 1'b0, '0, '0);
        end else begin
          if ($urandom_range(99) < 8) hold_pattern = RAW_W'($urandom_range(15));
          if (pick >= 90) begin
            raw = RAW_W'($urandom_range(15));
          end else if (pick >= 80) begin
            raw = hold_pattern ^ (RAW_W'(1) << $urandom_range(RAW_W - 1));
          end else begin
            raw = hold_pattern;
          end
          send_item(MODE_TICK, raw, 1'b0, '0, '0);
        end
      end
    end

    send_idle_pct = 0;
    wait_idle();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/bdar_pkg.sv
rtl/bdar_cfg_regs.sv
rtl/bdar_lane.sv
rtl/button_debounce_autorepeat_unit.sv
tb/tb_button_debounce_autorepeat_unit.sv
